// ===== rtl/stq_pkg.sv =====
// ----------------------------------------------------------------------------
// stq_pkg
// Shared types and codes for the sorted timer queue.
// ----------------------------------------------------------------------------
package stq_pkg;

    localparam int DEPTH_DEF   = 16;
    localparam int MAX_RESULTS = 16;
    localparam int DUE_W       = 48;
    localparam int ID_W        = 16;
    localparam int DELAY_W     = 32;
    localparam int NW          = $clog2(MAX_RESULTS + 1);

    // request codes (s_tuser)
    localparam logic [1:0] FUNC_SCHED  = 2'd0;
    localparam logic [1:0] FUNC_CANCEL = 2'd1;
    localparam logic [1:0] FUNC_TICK   = 2'd2;

    // result kinds (m_tuser)
    localparam logic [1:0] KIND_ID      = 2'd0;
    localparam logic [1:0] KIND_CANCEL  = 2'd1;
    localparam logic [1:0] KIND_EXPIRED = 2'd2;
    localparam logic [1:0] KIND_REJECT  = 2'd3;

    typedef struct packed {
        logic [DUE_W-1:0] due;
        logic [ID_W-1:0]  id;
    } entry_t;

    localparam int ENTRY_W = DUE_W + ID_W;

    typedef struct packed {
        logic [1:0]      kind;
        logic [ID_W-1:0] job_id;
        logic            found;
        logic            last;
    } res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCH_CMP,
        ST_SCH_INS,
        ST_CAN_SCAN,
        ST_TICK_RD,
        ST_TICK_CHK,
        ST_RESP
    } st_t;

endpackage

// ===== rtl/stq_ram.sv =====
// ----------------------------------------------------------------------------
// stq_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module stq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/stq_out.sv =====
// ----------------------------------------------------------------------------
// stq_out
// Output register for the result stream; frees the controller from the sink.
// ----------------------------------------------------------------------------
module stq_out (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          res_valid,
    input  stq_pkg::res_t res,
    output logic          res_ready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [23:0]   m_tdata,
    output logic [1:0]    m_tuser,
    output logic          m_tlast
);
    import stq_pkg::*;

    logic valid_reg, valid_next;
    res_t data_reg;

    assign res_ready = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (res_valid && res_ready) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            data_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {7'd0, data_reg.found, data_reg.job_id};
    assign m_tuser  = data_reg.kind;
    assign m_tlast  = data_reg.last;

endmodule

// ===== rtl/stq_ctrl.sv =====
// ----------------------------------------------------------------------------
// stq_ctrl
// Request sequencer: walks the entry RAM (a circular buffer kept in due order)
// to insert, cancel and expire timers.
// ----------------------------------------------------------------------------
module stq_ctrl #(
    parameter int DEPTH = stq_pkg::DEPTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   func,
    input  logic [stq_pkg::DELAY_W-1:0]  delay_ms,
    input  logic [stq_pkg::ID_W-1:0]     cancel_id,
    output logic                         ram_we,
    output logic [$clog2(DEPTH)-1:0]     ram_waddr,
    output stq_pkg::entry_t              ram_wdata,
    output logic [$clog2(DEPTH)-1:0]     ram_raddr,
    input  stq_pkg::entry_t              ram_rdata,
    output logic                         res_valid,
    output stq_pkg::res_t                res,
    input  logic                         res_ready
);
    import stq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW:0]    DEPTH_V = (AW + 1)'(DEPTH);
    localparam logic [CW-1:0]  FULL_V  = CW'(DEPTH);
    localparam logic [NW-1:0]  MAX_N   = NW'(MAX_RESULTS);

    st_t              state_reg, state_next;
    logic [AW-1:0]    head_reg, head_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [DUE_W-1:0] now_reg, now_next;
    logic [ID_W-1:0]  next_id_reg, next_id_next;
    logic [NW-1:0]    n_reg, n_next;
    logic             hold_valid_reg, hold_valid_next;
    logic [AW-1:0]    idx_reg, idx_next;
    logic [DUE_W-1:0] due_reg, due_next;
    res_t             hold_reg, hold_next;

    logic             in_fire;
    logic [DUE_W:0]   due_sum;
    logic [DUE_W-1:0] due_sat;
    logic             is_due;
    logic             later;
    logic             id_match;
    logic             scan_end;

    // logical queue position to RAM address
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] l, input logic [AW-1:0] h);
        logic [AW:0] s;
        s = {1'b0, h} + {1'b0, l};
        if (s >= DEPTH_V) begin
            s = s - DEPTH_V;
        end
        return s[AW-1:0];
    endfunction

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;

    assign due_sum  = {1'b0, now_reg} + {{(DUE_W + 1 - DELAY_W){1'b0}}, delay_ms};
    assign due_sat  = due_sum[DUE_W] ? {DUE_W{1'b1}} : due_sum[DUE_W-1:0];
    assign is_due   = (ram_rdata.due <= now_reg);
    assign later    = (ram_rdata.due > due_reg);
    assign id_match = (ram_rdata.id == hold_reg.job_id);
    assign scan_end = ((CW'(idx_reg) + CW'(1)) == count_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    case (func)
                        FUNC_SCHED: begin
                            if (count_reg == FULL_V) begin
                                state_next = ST_RESP;
                            end else if (count_reg == '0) begin
                                state_next = ST_SCH_INS;
                            end else begin
                                state_next = ST_SCH_CMP;
                            end
                        end
                        FUNC_CANCEL: begin
                            state_next = (count_reg == '0) ? ST_RESP : ST_CAN_SCAN;
                        end
                        FUNC_TICK: state_next = ST_TICK_RD;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SCH_CMP: begin
                if (!later || idx_reg == '0) begin
                    state_next = ST_SCH_INS;
                end
            end
            ST_SCH_INS: state_next = ST_RESP;
            ST_CAN_SCAN: begin
                if (scan_end) begin
                    state_next = ST_RESP;
                end
            end
            ST_TICK_RD: begin
                if (count_reg == '0 || n_reg == MAX_N) begin
                    state_next = hold_valid_reg ? ST_RESP : ST_IDLE;
                end else begin
                    state_next = ST_TICK_CHK;
                end
            end
            ST_TICK_CHK: begin
                if (!is_due) begin
                    state_next = hold_valid_reg ? ST_RESP : ST_IDLE;
                end else if (!hold_valid_reg || res_ready) begin
                    state_next = ST_TICK_RD;
                end
            end
            ST_RESP: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb begin
        head_next       = head_reg;
        count_next      = count_reg;
        now_next        = now_reg;
        next_id_next    = next_id_reg;
        n_next          = n_reg;
        hold_valid_next = hold_valid_reg;
        idx_next        = idx_reg;
        due_next        = due_reg;
        hold_next       = hold_reg;
        ram_we          = 1'b0;
        ram_waddr       = phys(idx_reg, head_reg);
        ram_wdata       = ram_rdata;
        ram_raddr       = head_reg;
        res_valid       = 1'b0;
        res             = hold_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    case (func)
                        FUNC_SCHED: begin
                            if (count_reg == FULL_V) begin
                                hold_next = '{kind: KIND_REJECT, job_id: '0,
                                              found: 1'b1, last: 1'b1};
                            end else begin
                                due_next     = due_sat;
                                next_id_next = next_id_reg + ID_W'(1);
                                hold_next    = '{kind: KIND_ID, job_id: next_id_reg + ID_W'(1),
                                                 found: 1'b1, last: 1'b1};
                                // walk back from the tail
                                idx_next  = (count_reg == '0) ? '0 : AW'(count_reg - CW'(1));
                                ram_raddr = phys(AW'(count_reg - CW'(1)), head_reg);
                            end
                        end
                        FUNC_CANCEL: begin
                            hold_next = '{kind: KIND_CANCEL, job_id: cancel_id,
                                          found: 1'b0, last: 1'b1};
                            idx_next  = '0;
                            ram_raddr = head_reg;
                        end
                        FUNC_TICK: begin
                            now_next        = now_reg + DUE_W'(1);
                            n_next          = '0;
                            hold_valid_next = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCH_CMP: begin
                if (later) begin
                    // shift one slot toward the tail
                    ram_we    = 1'b1;
                    ram_waddr = phys(idx_reg + AW'(1), head_reg);
                    ram_wdata = ram_rdata;
                    if (idx_reg != '0) begin
                        idx_next  = idx_reg - AW'(1);
                        ram_raddr = phys(idx_reg - AW'(1), head_reg);
                    end
                end else begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            ST_SCH_INS: begin
                ram_we     = 1'b1;
                ram_waddr  = phys(idx_reg, head_reg);
                ram_wdata  = '{due: due_reg, id: hold_reg.job_id};
                count_next = count_reg + CW'(1);
            end
            ST_CAN_SCAN: begin
                if (hold_reg.found) begin
                    // close the gap behind the removed entry
                    ram_we    = 1'b1;
                    ram_waddr = phys(idx_reg - AW'(1), head_reg);
                    ram_wdata = ram_rdata;
                end else if (id_match) begin
                    hold_next.found = 1'b1;
                end
                if (scan_end) begin
                    if (hold_reg.found || id_match) begin
                        count_next = count_reg - CW'(1);
                    end
                end else begin
                    idx_next  = idx_reg + AW'(1);
                    ram_raddr = phys(idx_reg + AW'(1), head_reg);
                end
            end
            ST_TICK_RD: begin
                ram_raddr = head_reg;
            end
            ST_TICK_CHK: begin
                ram_raddr = head_reg;
                if (is_due) begin
                    // previous expiry goes out once the next one is known to follow
                    res_valid = hold_valid_reg;
                    res.last  = 1'b0;
                    if (!hold_valid_reg || res_ready) begin
                        hold_next       = '{kind: KIND_EXPIRED, job_id: ram_rdata.id,
                                            found: 1'b1, last: 1'b0};
                        hold_valid_next = 1'b1;
                        head_next       = ({1'b0, head_reg} + (AW + 1)'(1) == DEPTH_V) ?
                                          '0 : head_reg + AW'(1);
                        count_next      = count_reg - CW'(1);
                        n_next          = n_reg + NW'(1);
                    end
                end
            end
            ST_RESP: begin
                res_valid = 1'b1;
                res.last  = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            head_reg       <= '0;
            count_reg      <= '0;
            now_reg        <= '0;
            next_id_reg    <= '0;
            n_reg          <= '0;
            hold_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            now_reg        <= now_next;
            next_id_reg    <= next_id_next;
            n_reg          <= n_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg  <= idx_next;
        due_reg  <= due_next;
        hold_reg <= hold_next;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_V)
        else $error("entry count above depth");

    a_burst_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= MAX_N)
        else $error("tick burst above limit");

    a_full_reject: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && func == FUNC_SCHED && count_reg == FULL_V
        |=> state_reg == ST_RESP && hold_reg.kind == KIND_REJECT && count_reg == FULL_V)
        else $error("full queue did not reject schedule");

    a_idle_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE && !in_fire |=> state_reg == ST_IDLE && $stable(count_reg))
        else $error("left idle without a request");

endmodule

// ===== rtl/sorted_timer_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_timer_queue
// Timer queue holding pending jobs sorted by due time, with expiry on tick.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one request per handshake. s_tuser picks schedule, cancel or
//   tick; s_tdata carries delay_ms and cancel_id. Request code 3 is ignored.
//   m_* channel: results. m_tuser gives the kind, m_tdata the job id and the
//   found flag, m_tlast marks the final result of a request.
//   Entries live in one RAM used as a circular buffer in due order.
//   Schedule walks back from the tail, shifting each entry due later than the
//   new one a slot toward the tail, then writes the new entry; a full queue
//   rejects it. Cancel scans the pending entries from the head and closes
//   the gap behind a match. Tick expires due entries from the head, at most
//   16 per tick. Each step of the RAM walk waits on the registered read.
//   One request is worked on at a time; s_tready is high while idle.
//   A result waits in an output register, so a new request is taken while
//   the sink stalls; the block holds further results until m_tready.
//   Reset empties the queue, clears the millisecond clock and the id
//   counter; the RAM needs no clearing pass.
// ----------------------------------------------------------------------------
module sorted_timer_queue #(
    parameter int DEPTH = stq_pkg::DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // delay_ms[31:0], cancel_id[47:32]
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // job_id[15:0], found[16], zero[23:17]
    output logic [1:0]  m_tuser,   // kind[1:0]
    output logic        m_tlast
);
    import stq_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    entry_t        ram_wdata;
    entry_t        ram_rdata;
    logic          res_valid;
    logic          res_ready;
    res_t          res;

    stq_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .func      (s_tuser),
        .delay_ms  (s_tdata[31:0]),
        .cancel_id (s_tdata[47:32]),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready)
    );

    stq_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    stq_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stream-level test of sorted_timer_queue. Requests come from a list built at
// time zero and are sent in bursts with random gaps. Each accepted request is
// run through a behavioral copy of the timer list, and every result on the
// master side is compared field by field with the oldest pending event. A
// short steady stretch runs with no sender gaps and no sink stalls.
// ----------------------------------------------------------------------------
module tb;
    import stq_pkg::*;

    localparam int DEPTH          = DEPTH_DEF;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TAIL_CYCLES    = 2 * DEPTH + 40;
    localparam int STEADY_PAIRS   = 8;

    typedef struct {
        logic [1:0]  func;
        logic [31:0] delay;
        logic [15:0] cid;
        bit          steady;      // no sender gaps, no sink stalls
        bit          drain_first; // wait until all results are back
        bit          sink_hold;   // start the long sink hold-off
    } timer_req_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;   // delay_ms[31:0], cancel_id[47:32]
    logic [1:0]  s_tuser  = '0;   // func[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // job_id[15:0], found[16], zero[23:17]
    logic [1:0]  m_tuser;         // kind[1:0]
    logic        m_tlast;

    sorted_timer_queue #(.DEPTH(DEPTH)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #10 aclk = ~aclk;

    // request list and generator state
    timer_req_t  request_list[$];
    bit          gen_steady = 0;
    bit          gen_drain  = 0;
    bit          gen_hold   = 0;
    logic [15:0] gen_id     = '0;

    // behavioral timer list
    entry_t      timers[$];
    logic [47:0] clock_ms;
    logic [15:0] id_ctr;
    res_t        pending_events[$];
    bit          queue_drained = 1'b1;
    int          mismatch_count = 0;
    res_t        want, got;

    // driver / sink state
    timer_req_t  next_req;
    int          gap_left   = 0;
    int          burst_left = 0;
    bit          steady_now = 0;
    bit          hold_trig  = 0;
    bit          hold_done  = 0;
    int          hold_left  = 0;
    int          phase_left = 0;
    logic [7:0]  rdy_pattern = 8'hFF;
    int          idle_cycles = 0;

    task automatic add_req(input logic [1:0] func, input logic [31:0] delay,
                           input logic [15:0] cid);
        timer_req_t r;
        r.func        = func;
        r.delay       = delay;
        r.cid         = cid;
        r.steady      = gen_steady;
        r.drain_first = gen_drain;
        r.sink_hold   = gen_hold;
        request_list.push_back(r);
        gen_drain = 0;
        gen_hold  = 0;
        if (func == FUNC_SCHED)
            gen_id = gen_id + 16'd1;
    endtask

    function automatic logic [31:0] rand_delay();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 14)
            return $urandom_range(0, 12);
        else if (sel < 17)
            return $urandom_range(0, 400);
        return $urandom;
    endfunction

    // mostly recent ids so that cancels hit; the rest anywhere in the id space
    task automatic add_random_requests(input int count);
        int made;
        int pick;
        int n;
        made = 0;
        while (made < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                n = $urandom_range(6, 18);
                repeat (n) add_req(FUNC_SCHED, rand_delay(), 16'($urandom));
                made += n;
            end else if (pick < 40) begin
                add_req(FUNC_SCHED, rand_delay(), 16'($urandom));
                made++;
            end else if (pick < 62) begin
                if ($urandom_range(0, 9) < 7)
                    add_req(FUNC_CANCEL, $urandom,
                            gen_id - 16'($urandom_range(0, 10)));
                else
                    add_req(FUNC_CANCEL, $urandom, 16'($urandom));
                made++;
            end else if (pick < 96) begin
                add_req(FUNC_TICK, $urandom, 16'($urandom));
                made++;
            end else begin
                add_req(2'd3, $urandom, 16'($urandom));
            end
        end
    endtask

    function automatic res_t make_event(input logic [1:0] kind, input logic [15:0] id,
                                        input logic found, input logic last);
        res_t r;
        r.kind   = kind;
        r.job_id = id;
        r.found  = found;
        r.last   = last;
        return r;
    endfunction

    // applies one accepted request to the timer list and queues its results
    task automatic apply_timer_request(input logic [1:0] func, input logic [31:0] delay,
                                       input logic [15:0] cid);
        logic [48:0] sum;
        entry_t      ent;
        int          pos;
        int          n;
        bit          hit;
        bit          more;
        case (func)
            FUNC_SCHED: begin
                if (timers.size() >= DEPTH) begin
                    pending_events.push_back(make_event(KIND_REJECT, '0, 1'b1, 1'b1));
                end else begin
                    sum    = {1'b0, clock_ms} + {17'd0, delay};
                    ent.due = sum[48] ? {48{1'b1}} : sum[47:0];
                    id_ctr = id_ctr + 16'd1;
                    ent.id = id_ctr;
                    pos = 0;
                    while (pos < timers.size() && timers[pos].due <= ent.due)
                        pos++;
                    timers.insert(pos, ent);
                    pending_events.push_back(make_event(KIND_ID, id_ctr, 1'b1, 1'b1));
                end
            end
            FUNC_CANCEL: begin
                hit = 0;
                for (pos = 0; pos < timers.size(); pos++) begin
                    if (timers[pos].id == cid) begin
                        timers.delete(pos);
                        hit = 1;
                        break;
                    end
                end
                pending_events.push_back(make_event(KIND_CANCEL, cid, hit, 1'b1));
            end
            FUNC_TICK: begin
                clock_ms = clock_ms + 48'd1;
                n = 0;
                while (n < MAX_RESULTS && timers.size() > 0
                       && timers[0].due <= clock_ms) begin
                    more = (n + 1 < MAX_RESULTS) && (timers.size() > 1)
                           && (timers[1].due <= clock_ms);
                    pending_events.push_back(make_event(KIND_EXPIRED, timers[0].id,
                                                        1'b1, !more));
                    timers.delete(0);
                    n++;
                end
            end
            default: ;
        endcase
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            gap_left   <= 0;
            burst_left <= 0;
        end else if (!(s_tvalid && !s_tready)) begin
            if (gap_left > 0) begin
                s_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (request_list.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (request_list[0].drain_first && (s_tvalid || !queue_drained)) begin
                // drop valid first so queue_drained sees the last request's results
                s_tvalid <= 1'b0;
            end else begin
                next_req = request_list[0];
                request_list.delete(0);
                s_tvalid   <= 1'b1;
                s_tuser    <= next_req.func;
                s_tdata    <= {next_req.cid, next_req.delay};
                steady_now <= next_req.steady;
                if (next_req.sink_hold)
                    hold_trig <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 12);
                    if (next_req.steady || $urandom_range(0, 3) == 0)
                        gap_left <= 0;
                    else
                        gap_left <= $urandom_range(1, 15);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // sink: rotating ready pattern, plus one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            hold_left  <= 0;
            hold_done  <= 1'b0;
            phase_left <= 0;
        end else if (hold_trig && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (steady_now) begin
            m_tready <= 1'b1;
        end else begin
            if (phase_left == 0) begin
                phase_left  <= $urandom_range(8, 60);
                rdy_pattern <= ($urandom_range(0, 3) == 0) ? 8'hFF
                                                           : (8'($urandom) | 8'h01);
            end else begin
                phase_left  <= phase_left - 1;
                rdy_pattern <= {rdy_pattern[0], rdy_pattern[7:1]};
            end
            m_tready <= rdy_pattern[0];
        end
    end

    // monitor: results are checked before the request of the same edge is applied
    always @(posedge aclk) begin
        if (!aresetn) begin
            timers.delete();
            pending_events.delete();
            clock_ms = '0;
            id_ctr   = '0;
            queue_drained <= 1'b1;
        end else begin
            if (m_tvalid && m_tready) begin
                got.kind   = m_tuser;
                got.job_id = m_tdata[15:0];
                got.found  = m_tdata[16];
                got.last   = m_tlast;
                if (pending_events.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: kind=%0d id=%0d found=%0d last=%0d",
                                 got.kind, got.job_id, got.found, got.last);
                end else begin
                    want = pending_events[0];
                    pending_events.delete(0);
                    if (got.kind !== want.kind || got.job_id !== want.job_id ||
                        got.found !== want.found || got.last !== want.last) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: want kind=%0d id=%0d found=%0d last=%0d,",
                                     want.kind, want.job_id, want.found, want.last,
                                     " got kind=%0d id=%0d found=%0d last=%0d",
                                     got.kind, got.job_id, got.found, got.last);
                    end
                end
            end
            if (s_tvalid && s_tready)
                apply_timer_request(s_tuser, s_tdata[31:0], s_tdata[47:32]);
            queue_drained <= (pending_events.size() == 0);
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        // directed: expiry, head and tail cancel, miss, full queue, 16 due at once
        add_req(FUNC_SCHED, 32'd0, 16'd0);              // id 1, due now
        add_req(FUNC_TICK, 32'd0, 16'd0);               // id 1 expires
        add_req(FUNC_SCHED, 32'hFFFF_FFFF, 16'hFFFF);   // id 2, far out
        add_req(FUNC_SCHED, 32'd1, 16'd0);              // id 3
        add_req(FUNC_SCHED, 32'd0, 16'd0);              // id 4 goes to the head
        add_req(FUNC_CANCEL, 32'd0, 16'd4);
        add_req(FUNC_CANCEL, 32'hFFFF_FFFF, 16'hFFFF);  // no match
        add_req(FUNC_CANCEL, 32'd0, 16'd2);
        repeat (DEPTH - 1) add_req(FUNC_SCHED, 32'd1, 16'd0);  // equal due times
        add_req(FUNC_SCHED, 32'd7, 16'd0);              // rejected, queue full
        add_req(FUNC_TICK, 32'd0, 16'd0);               // all sixteen expire
        gen_id = 16'd19;

        // steady stretch: two timers held far out, short-lived ones pass by
        gen_steady = 1;
        add_req(FUNC_SCHED, 32'hFFFF_FFFF, 16'd0);      // id 20
        add_req(FUNC_SCHED, 32'hFFFF_FFFF, 16'd0);      // id 21
        repeat (STEADY_PAIRS) begin
            add_req(FUNC_SCHED, 32'd0, 16'd0);
            add_req(FUNC_TICK, 32'd0, 16'd0);
        end
        gen_steady = 0;
        add_req(FUNC_SCHED, 32'd1000, 16'd0);           // id 30, goes to the head
        add_req(FUNC_SCHED, 32'hFFFF_FFFF, 16'd0);      // id 31, goes to the tail
        add_req(FUNC_CANCEL, 32'd0, 16'd20);
        add_req(FUNC_CANCEL, 32'd0, 16'd21);
        add_req(FUNC_CANCEL, 32'd0, 16'd20);            // already gone
        add_req(FUNC_CANCEL, 32'd0, 16'd21);
        add_req(FUNC_CANCEL, 32'd0, 16'd20);

        add_random_requests(100);
        gen_drain = 1;
        gen_hold  = 1;
        add_random_requests(100);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        @(negedge aclk);
        while (!(request_list.size() == 0 && !s_tvalid && queue_drained))
            @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (mismatch_count == 0 && pending_events.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== sorted_timer_queue.f =====
rtl/stq_pkg.sv
rtl/stq_ram.sv
rtl/stq_out.sv
rtl/stq_ctrl.sv
rtl/sorted_timer_queue.sv
bench/tb.sv
